### sv/lcas_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and the cell rule of the toroidal life-like automaton.
package lcas_pkg;

    localparam int LCAS_MAX_SIDE = 64;
    localparam int MIN_SIDE      = 3;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 12;
    localparam int SIDE_W = 7;
    localparam int MASK_W = 9;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MASK = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_RST    = 7'd64;
    localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;

    // Each column holds {down, middle, up}; the center cell is col_c[1].
    function automatic logic next_cell(
        input logic [2:0]        col_l,
        input logic [2:0]        col_c,
        input logic [2:0]        col_r,
        input logic [MASK_W-1:0] birth,
        input logic [MASK_W-1:0] survive
    );
        logic [3:0] cnt;
        cnt = 4'(col_l[0]) + 4'(col_l[1]) + 4'(col_l[2])
            + 4'(col_c[0]) + 4'(col_c[2])
            + 4'(col_r[0]) + 4'(col_r[1]) + 4'(col_r[2]);
        return col_c[1] ? survive[cnt] : birth[cnt];
    endfunction

endpackage

### sv/lcas_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands, results and configuration writes.
interface lcas_item_if;
    logic                       valid;
    logic                       ready;
    logic [lcas_pkg::CMD_W-1:0] command;
    logic [lcas_pkg::IDX_W-1:0] cell_index;
    logic                       cell_value;

    modport source (output valid, command, cell_index, cell_value, input ready);
    modport sink   (input valid, command, cell_index, cell_value, output ready);
endinterface

interface lcas_result_if;
    logic valid;
    logic ready;
    logic read_value;
    logic done_res;

    modport source (output valid, read_value, done_res, input ready);
    modport sink   (input valid, read_value, done_res, output ready);
endinterface

interface lcas_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcas_pkg::CFG_IDX_W-1:0]  index;
    logic [lcas_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/lcas_grid_ram.sv
`timescale 1ns / 1ps
// One-bit-wide grid memory with one write port and one registered read port.
module lcas_grid_ram #(
    parameter int AW = 13
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic grid_mem [2**AW];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            grid_mem[waddr] <= wdata;
        end
        rdata_reg <= grid_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/life_cellular_automaton_step.sv
`timescale 1ns / 1ps
// Top level of the toroidal life-like automaton: command sequencer and grid banks.
//
// The grid lives in one single-port-read memory split into two banks; an
// advance reads the current bank through a sliding 3x3 window and writes the
// next generation into the other bank, then copies the cells beyond the grid
// in use and swaps banks. After reset a clearing pass zeroes the grid, during
// which no command is accepted (configuration writes are). A write passes
// through the execute and done states before its result beat is offered, and a
// read also through a read-wait state between them. An advance evaluates the
// grid in use cell by cell, then copies the rest, then hands off: every cell
// needs three memory reads for its new window column, one window shift and one
// evaluation, all through the single memory read port, and every row starts
// with a setup state and a three-column preload. A result beat that is held
// off stalls the next command.
module life_cellular_automaton_step #(
    parameter int MAX_SIDE = lcas_pkg::LCAS_MAX_SIDE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lcas_item_if.sink            item,
    lcas_result_if.source        result,
    lcas_cfg_if.sink             cfg
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IW    = $clog2(CELLS);
    localparam int AW    = IW + 1;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int PW    = $clog2(MAX_SIDE);
    localparam int NW    = 2 * SW;
    localparam int CW    = (SW > lcas_pkg::SIDE_W) ? SW : lcas_pkg::SIDE_W;
    localparam int KW    = (NW > lcas_pkg::IDX_W) ? NW : lcas_pkg::IDX_W;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EXEC   = 4'd2;
    localparam logic [3:0] ST_RDWAIT = 4'd3;
    localparam logic [3:0] ST_ROW    = 4'd4;
    localparam logic [3:0] ST_FETCH  = 4'd5;
    localparam logic [3:0] ST_SHIFT  = 4'd6;
    localparam logic [3:0] ST_EVAL   = 4'd7;
    localparam logic [3:0] ST_COPY   = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    logic [3:0]                     state_reg, state_next;
    logic                           bank_reg, bank_next;
    logic [IW:0]                    cnt_reg, cnt_next;
    logic [lcas_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [lcas_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                           val_reg, val_next;
    logic                           hit_reg, hit_next;
    logic                           res_rd_reg, res_rd_next;
    logic                           res_done_reg, res_done_next;
    logic [PW-1:0]                  row_reg, row_next;
    logic [PW-1:0]                  col_reg, col_next;
    logic [PW-1:0]                  fcol_reg, fcol_next;
    logic [1:0]                     ph_reg, ph_next;
    logic [1:0]                     pre_reg, pre_next;
    logic [IW-1:0]                  row_base_reg, row_base_next;
    logic [IW-1:0]                  up_base_reg, up_base_next;
    logic [IW-1:0]                  dn_base_reg, dn_base_next;
    logic [1:0]                     newcol_reg, newcol_next;
    logic [2:0]                     win0_reg, win0_next;
    logic [2:0]                     win1_reg, win1_next;
    logic [2:0]                     win2_reg, win2_next;
    logic                           pend_reg, pend_next;
    logic [IW-1:0]                  cp_prev_reg, cp_prev_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_rd_reg, out_rd_next;
    logic                           out_done_reg, out_done_next;

    logic [lcas_pkg::SIDE_W-1:0]    side_reg;
    logic [lcas_pkg::MASK_W-1:0]    birth_reg;
    logic [lcas_pkg::MASK_W-1:0]    survive_reg;
    logic [SW-1:0]                  side_q_reg;
    logic [PW-1:0]                  last_col_reg;
    logic [NW-1:0]                  n_reg;

    logic [CW-1:0]                  side_ext;
    logic [SW-1:0]                  act_side;
    logic                           in_range;
    logic [PW-1:0]                  fcol_inc;
    logic [IW-1:0]                  fetch_base;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic                           ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic                           ram_rdata;

    lcas_grid_ram #(
        .AW (AW)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Side length clamped to the supported range.
    always_comb
    begin
        side_ext = CW'(side_reg);
        if (side_ext < CW'(lcas_pkg::MIN_SIDE))
        begin
            act_side = SW'(lcas_pkg::MIN_SIDE);
        end
        else if (side_ext > CW'(MAX_SIDE))
        begin
            act_side = SW'(MAX_SIDE);
        end
        else
        begin
            act_side = SW'(side_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= lcas_pkg::SIDE_RST;
            birth_reg   <= lcas_pkg::BIRTH_RST;
            survive_reg <= lcas_pkg::SURVIVE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                lcas_pkg::REG_SIDE_LENGTH:  side_reg    <= cfg.data[lcas_pkg::SIDE_W-1:0];
                lcas_pkg::REG_BIRTH_MASK:   birth_reg   <= cfg.data[lcas_pkg::MASK_W-1:0];
                lcas_pkg::REG_SURVIVE_MASK: survive_reg <= cfg.data[lcas_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Derived geometry, registered from the clamped side length.
    always_ff @(posedge clk)
    begin
        side_q_reg   <= act_side;
        last_col_reg <= PW'(act_side - SW'(1));
        n_reg        <= NW'(act_side * act_side);
    end

    assign cfg.ready = 1'b1;
    assign item.ready = (state_reg == ST_IDLE);

    assign result.valid      = out_valid_reg;
    assign result.read_value = out_rd_reg;
    assign result.done_res   = out_done_reg;

    assign in_range = (KW'(idx_reg) < KW'(n_reg));
    assign fcol_inc = (fcol_reg == last_col_reg) ? '0 : PW'(fcol_reg + PW'(1));

    always_comb
    begin
        case (ph_reg)
            2'd0:    fetch_base = up_base_reg;
            2'd1:    fetch_base = row_base_reg;
            default: fetch_base = dn_base_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        hit_next      = hit_reg;
        res_rd_next   = res_rd_reg;
        res_done_next = res_done_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        fcol_next     = fcol_reg;
        ph_next       = ph_reg;
        pre_next      = pre_reg;
        row_base_next = row_base_reg;
        up_base_next  = up_base_reg;
        dn_base_next  = dn_base_reg;
        newcol_next   = newcol_reg;
        win0_next     = win0_reg;
        win1_next     = win1_reg;
        win2_next     = win2_reg;
        pend_next     = pend_reg;
        cp_prev_next  = cp_prev_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_done_next  = out_done_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = 1'b0;
        ram_raddr = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {1'b0, cnt_reg[IW-1:0]};
                cnt_next  = (IW+1)'(cnt_reg + (IW+1)'(1));
                if (cnt_reg[IW-1:0] == IW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next   = item.command;
                    idx_next   = item.cell_index;
                    val_next   = item.cell_value;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                hit_next      = in_range;
                res_rd_next   = 1'b0;
                res_done_next = 1'b1;
                ram_raddr     = {bank_reg, IW'(idx_reg)};
                unique case (cmd_reg)
                    lcas_pkg::CMD_WRITE:
                    begin
                        ram_we     = in_range;
                        ram_waddr  = {bank_reg, IW'(idx_reg)};
                        ram_wdata  = val_reg;
                        state_next = ST_DONE;
                    end
                    lcas_pkg::CMD_READ:
                    begin
                        state_next = ST_RDWAIT;
                    end
                    lcas_pkg::CMD_ADVANCE:
                    begin
                        row_next      = '0;
                        col_next      = '0;
                        row_base_next = '0;
                        up_base_next  = IW'(n_reg - NW'(side_q_reg));
                        dn_base_next  = IW'(side_q_reg);
                        state_next    = ST_ROW;
                    end
                    default:
                    begin
                        res_done_next = 1'b0;
                        state_next    = ST_DONE;
                    end
                endcase
            end

            ST_RDWAIT:
            begin
                res_rd_next = hit_reg & ram_rdata;
                state_next  = ST_DONE;
            end

            // The window is preloaded with the columns left of, at and right of column zero.
            ST_ROW:
            begin
                fcol_next  = last_col_reg;
                pre_next   = 2'd0;
                ph_next    = 2'd0;
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                ram_raddr = {bank_reg, IW'(fetch_base + IW'(fcol_reg))};
                if (ph_reg == 2'd1)
                begin
                    newcol_next[0] = ram_rdata;
                end
                else if (ph_reg == 2'd2)
                begin
                    newcol_next[1] = ram_rdata;
                end
                if (ph_reg == 2'd2)
                begin
                    ph_next    = 2'd0;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end

            ST_SHIFT:
            begin
                win0_next = win1_reg;
                win1_next = win2_reg;
                win2_next = {ram_rdata, newcol_reg};
                if (pre_reg != 2'd2)
                begin
                    pre_next   = pre_reg + 2'd1;
                    fcol_next  = fcol_inc;
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                ram_we    = 1'b1;
                ram_waddr = {~bank_reg, IW'(row_base_reg + IW'(col_reg))};
                ram_wdata = lcas_pkg::next_cell(win0_reg, win1_reg, win2_reg,
                                                birth_reg, survive_reg);
                if (col_reg == last_col_reg)
                begin
                    if (row_reg == last_col_reg)
                    begin
                        cnt_next   = (IW+1)'(n_reg);
                        pend_next  = 1'b0;
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        row_next      = PW'(row_reg + PW'(1));
                        col_next      = '0;
                        up_base_next  = row_base_reg;
                        row_base_next = dn_base_reg;
                        if (PW'(row_reg + PW'(1)) == last_col_reg)
                        begin
                            dn_base_next = '0;
                        end
                        else
                        begin
                            dn_base_next = IW'(dn_base_reg + IW'(side_q_reg));
                        end
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    col_next   = PW'(col_reg + PW'(1));
                    fcol_next  = fcol_inc;
                    state_next = ST_FETCH;
                end
            end

            // Cells beyond the grid in use are carried into the new bank unchanged.
            ST_COPY:
            begin
                ram_raddr    = {bank_reg, cnt_reg[IW-1:0]};
                ram_we       = pend_reg;
                ram_waddr    = {~bank_reg, cp_prev_reg};
                ram_wdata    = ram_rdata;
                cp_prev_next = cnt_reg[IW-1:0];
                if (cnt_reg == (IW+1)'(CELLS))
                begin
                    pend_next  = 1'b0;
                    bank_next  = ~bank_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    pend_next = 1'b1;
                    cnt_next  = (IW+1)'(cnt_reg + (IW+1)'(1));
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_done_next  = res_done_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            bank_reg      <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        hit_reg      <= hit_next;
        res_rd_reg   <= res_rd_next;
        res_done_reg <= res_done_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        fcol_reg     <= fcol_next;
        ph_reg       <= ph_next;
        pre_reg      <= pre_next;
        row_base_reg <= row_base_next;
        up_base_reg  <= up_base_next;
        dn_base_reg  <= dn_base_next;
        newcol_reg   <= newcol_next;
        win0_reg     <= win0_next;
        win1_reg     <= win1_next;
        win2_reg     <= win2_next;
        cp_prev_reg  <= cp_prev_next;
        out_rd_reg   <= out_rd_next;
        out_done_reg <= out_done_next;
    end

endmodule

### sv/lcas_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the automaton block and their attachment to the top level.
module lcas_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready,
    input logic result_read_value,
    input logic result_done_res
);

    // A result beat that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_read_value) && $stable(result_done_res))
    else $error("result beat changed while stalled");

    // The block works on one command at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("command accepted while another is in progress");

    // Only a completed read can report a live cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_read_value |-> result_done_res)
    else $error("read value set on an unfinished command");

    // A new result appears only when the block has finished and is ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> item_ready)
    else $error("result issued while a command is still in progress");

endmodule

bind life_cellular_automaton_step lcas_checker u_lcas_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_read_value (result.read_value),
    .result_done_res   (result.done_res)
);

### dv/tb_life_cellular_automaton_step.sv
`timescale 1ns / 1ps
// Self-checking testbench for life_cellular_automaton_step with its own grid predictor.
module tb_life_cellular_automaton_step;

    localparam int GRID_CELLS    = lcas_pkg::LCAS_MAX_SIDE * lcas_pkg::LCAS_MAX_SIDE;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int END_WAIT      = 60000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 35;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [lcas_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic read_value;
        logic done_res;
    } life_result_t;

    typedef enum logic {ROW_COMMAND, ROW_REGS} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic [lcas_pkg::CMD_W-1:0]       op;
        logic [lcas_pkg::IDX_W-1:0]       idx;
        logic                             val;
        logic                             fixed;
        life_result_t                     want;
        logic [lcas_pkg::CFG_DATA_W-1:0]  side_word;
        logic [lcas_pkg::CFG_DATA_W-1:0]  birth;
        logic [lcas_pkg::CFG_DATA_W-1:0]  survive;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lcas_item_if   cmd_bus ();
    lcas_result_if res_bus ();
    lcas_cfg_if    reg_bus ();

    life_cellular_automaton_step i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (cmd_bus),
        .result (res_bus),
        .cfg    (reg_bus)
    );

    // Predicted grid and rule registers.
    bit                          life_cells [GRID_CELLS];
    bit                          life_next  [GRID_CELLS];
    logic [lcas_pkg::SIDE_W-1:0] side_q    = lcas_pkg::SIDE_RST;
    logic [lcas_pkg::MASK_W-1:0] birth_q   = lcas_pkg::BIRTH_RST;
    logic [lcas_pkg::MASK_W-1:0] survive_q = lcas_pkg::SURVIVE_RST;

    life_result_t  pending_results [$];
    directed_row_t directed_rows [$];

    int fail_count    = 0;
    int src_idle_pct  = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("life_cellular_automaton_step verification failed");
        $finish;
    end

    function automatic void flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endfunction

    function automatic int unsigned live_side();
        int unsigned s;
        s = side_q;
        if (s < lcas_pkg::MIN_SIDE)
        begin
            s = lcas_pkg::MIN_SIDE;
        end
        else if (s > lcas_pkg::LCAS_MAX_SIDE)
        begin
            s = lcas_pkg::LCAS_MAX_SIDE;
        end
        return s;
    endfunction

    // Applies one command to the predicted grid and returns the result beat it causes.
    function automatic life_result_t predict_beat(
        input logic [lcas_pkg::CMD_W-1:0] op,
        input logic [lcas_pkg::IDX_W-1:0] idx,
        input logic                       val
    );
        life_result_t res;
        int unsigned  s, cells, r, c, dr, dc, cnt, here;
        res   = '0;
        s     = live_side();
        cells = s * s;
        case (op)
            lcas_pkg::CMD_WRITE:
            begin
                if (idx < cells)
                begin
                    life_cells[idx] = val;
                end
                res.done_res = 1'b1;
            end
            lcas_pkg::CMD_READ:
            begin
                if (idx < cells)
                begin
                    res.read_value = life_cells[idx];
                end
                res.done_res = 1'b1;
            end
            lcas_pkg::CMD_ADVANCE:
            begin
                // Every cell in use is judged on the old generation; cells beyond stay put.
                for (r = 0; r < s; r++)
                begin
                    for (c = 0; c < s; c++)
                    begin
                        cnt = 0;
                        for (dr = 0; dr < 3; dr++)
                        begin
                            for (dc = 0; dc < 3; dc++)
                            begin
                                if (dr != 1 || dc != 1)
                                begin
                                    cnt += life_cells[((r + s + dr - 1) % s) * s
                                                      + (c + s + dc - 1) % s];
                                end
                            end
                        end
                        here = r * s + c;
                        life_next[here] = life_cells[here] ? survive_q[cnt] : birth_q[cnt];
                    end
                end
                for (r = 0; r < cells; r++)
                begin
                    life_cells[r] = life_next[r];
                end
                res.done_res = 1'b1;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [lcas_pkg::MASK_W-1:0] rule_mask(
        input logic [lcas_pkg::MASK_W-1:0] conway
    );
        case ($urandom_range(0, 7))
            0, 1:    return conway;
            2:       return '0;
            3:       return '1;
            default: return lcas_pkg::MASK_W'($urandom());
        endcase
    endfunction

    function automatic directed_row_t checked_row(
        input logic [lcas_pkg::CMD_W-1:0] op,
        input logic [lcas_pkg::IDX_W-1:0] idx,
        input logic                       val,
        input logic                       rd,
        input logic                       done
    );
        directed_row_t row;
        row       = '0;
        row.kind  = ROW_COMMAND;
        row.op    = op;
        row.idx   = idx;
        row.val   = val;
        row.fixed = 1'b1;
        row.want  = '{read_value: rd, done_res: done};
        return row;
    endfunction

    function automatic directed_row_t model_row(
        input logic [lcas_pkg::CMD_W-1:0] op,
        input logic [lcas_pkg::IDX_W-1:0] idx,
        input logic                       val
    );
        directed_row_t row;
        row      = '0;
        row.kind = ROW_COMMAND;
        row.op   = op;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    function automatic directed_row_t reg_row(
        input logic [lcas_pkg::CFG_DATA_W-1:0] side_word,
        input logic [lcas_pkg::CFG_DATA_W-1:0] birth,
        input logic [lcas_pkg::CFG_DATA_W-1:0] survive
    );
        directed_row_t row;
        row           = '0;
        row.kind      = ROW_REGS;
        row.side_word = side_word;
        row.birth     = birth;
        row.survive   = survive;
        return row;
    endfunction

    task automatic send_command(
        input logic [lcas_pkg::CMD_W-1:0] op,
        input logic [lcas_pkg::IDX_W-1:0] idx,
        input logic                       val,
        input logic                       fixed,
        input life_result_t               fixed_res
    );
        life_result_t model_res;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= op;
        cmd_bus.cell_index <= idx;
        cmd_bus.cell_value <= val;
        do @(posedge clk); while (!cmd_bus.ready);
        // Valid stays up here: the next call either replaces the beat or drops it.
        model_res = predict_beat(op, idx, val);
        pending_results = {pending_results, (fixed ? fixed_res : model_res)};
    endtask

    task automatic await_idle();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(
        input logic [lcas_pkg::CFG_DATA_W-1:0] side_word,
        input logic [lcas_pkg::CFG_DATA_W-1:0] birth,
        input logic [lcas_pkg::CFG_DATA_W-1:0] survive
    );
        logic [lcas_pkg::CFG_DATA_W-1:0] words [3];
        logic [lcas_pkg::CFG_IDX_W-1:0]  regs  [3];
        int                              k;
        words = '{side_word, birth, survive};
        regs  = '{lcas_pkg::REG_SIDE_LENGTH, lcas_pkg::REG_BIRTH_MASK,
                  lcas_pkg::REG_SURVIVE_MASK};
        for (k = 0; k < 3; k++)
        begin
            reg_bus.valid <= 1'b1;
            reg_bus.index <= regs[k];
            reg_bus.data  <= words[k];
            do @(posedge clk); while (!reg_bus.ready);
            case (regs[k])
                lcas_pkg::REG_SIDE_LENGTH:  side_q    = words[k][lcas_pkg::SIDE_W-1:0];
                lcas_pkg::REG_BIRTH_MASK:   birth_q   = words[k][lcas_pkg::MASK_W-1:0];
                lcas_pkg::REG_SURVIVE_MASK: survive_q = words[k][lcas_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
        reg_bus.valid <= 1'b0;
    endtask

    // One rule setting followed by mostly in-grid writes, reads and advances.
    task automatic random_phase(input int unsigned count, input bit squeeze);
        logic [lcas_pkg::CFG_DATA_W-1:0] side_word;
        logic [lcas_pkg::CMD_W-1:0]      op;
        logic [lcas_pkg::IDX_W-1:0]      idx;
        int unsigned                     cells, pick, k;
        case ($urandom_range(0, 9))
            0:       side_word = lcas_pkg::CFG_DATA_W'($urandom_range(0, 2));
            1:       side_word = lcas_pkg::CFG_DATA_W'($urandom_range(9, 16));
            default: side_word = lcas_pkg::CFG_DATA_W'($urandom_range(3, 8));
        endcase
        // The upper data bits lie outside the side register and must be dropped.
        side_word[lcas_pkg::CFG_DATA_W-1:lcas_pkg::SIDE_W] = 2'($urandom());
        await_idle();
        write_regs(side_word, rule_mask(lcas_pkg::BIRTH_RST), rule_mask(lcas_pkg::SURVIVE_RST));
        if (squeeze)
        begin
            hold_token++;
        end
        cells = live_side() * live_side();
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            idx  = lcas_pkg::IDX_W'($urandom_range(0, cells - 1));
            if (pick < 42)
            begin
                op = lcas_pkg::CMD_WRITE;
            end
            else if (pick < 68)
            begin
                op = lcas_pkg::CMD_READ;
            end
            else if (pick < 80)
            begin
                op = lcas_pkg::CMD_ADVANCE;
            end
            else if (pick < 92)
            begin
                op = pick[0] ? lcas_pkg::CMD_READ : lcas_pkg::CMD_WRITE;
                if (cells < GRID_CELLS)
                begin
                    idx = lcas_pkg::IDX_W'($urandom_range(cells, GRID_CELLS - 1));
                end
            end
            else
            begin
                op  = CMD_UNUSED;
                idx = lcas_pkg::IDX_W'($urandom());
            end
            send_command(op, idx, 1'($urandom()), 1'b0, '0);
        end
    endtask

    // Result receiver: random back-pressure, plus a long hold on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            res_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_beat
        life_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_error($sformatf(
                    "result beat with nothing expected: read_value=%0b done_res=%0b",
                    res_bus.read_value, res_bus.done_res));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.read_value !== want.read_value)
                begin
                    flag_error($sformatf("read_value expected %0b got %0b",
                                         want.read_value, res_bus.read_value));
                end
                if (res_bus.done_res !== want.done_res)
                begin
                    flag_error($sformatf("done_res expected %0b got %0b",
                                         want.done_res, res_bus.done_res));
                end
            end
        end
    end

    initial
    begin
        int waited;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.command    <= lcas_pkg::CMD_WRITE;
        cmd_bus.cell_index <= '0;
        cmd_bus.cell_value <= 1'b0;
        reg_bus.valid      <= 1'b0;
        reg_bus.index      <= lcas_pkg::REG_SIDE_LENGTH;
        reg_bus.data       <= '0;

        // Default 64x64 Conway grid first, then a shrunken grid and an oversized side.
        directed_rows = '{
            checked_row(lcas_pkg::CMD_READ,    12'd0,    1'b0, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_READ,    12'd4095, 1'b0, 1'b0, 1'b1),
            checked_row(CMD_UNUSED,            12'd4095, 1'b1, 1'b0, 1'b0),
            checked_row(lcas_pkg::CMD_WRITE,   12'd0,    1'b1, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_WRITE,   12'd63,   1'b1, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_WRITE,   12'd4032, 1'b1, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_WRITE,   12'd4095, 1'b1, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_READ,    12'd4095, 1'b0, 1'b1, 1'b1),
            checked_row(lcas_pkg::CMD_WRITE,   12'd1,    1'b1, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_ADVANCE, 12'd0,    1'b0, 1'b0, 1'b1),
            model_row(lcas_pkg::CMD_READ,      12'd0,    1'b0),
            model_row(lcas_pkg::CMD_READ,      12'd1,    1'b0),
            model_row(lcas_pkg::CMD_READ,      12'd4094, 1'b0),
            reg_row(9'd0, 9'd511, 9'd0),
            checked_row(lcas_pkg::CMD_READ,    12'd9,    1'b0, 1'b0, 1'b1),
            checked_row(lcas_pkg::CMD_WRITE,   12'd9,    1'b1, 1'b0, 1'b1),
            model_row(lcas_pkg::CMD_READ,      12'd4,    1'b0),
            checked_row(lcas_pkg::CMD_ADVANCE, 12'd2048, 1'b1, 1'b0, 1'b1),
            model_row(lcas_pkg::CMD_READ,      12'd4,    1'b0),
            reg_row(9'd127, 9'd0, 9'd511),
            model_row(lcas_pkg::CMD_READ,      12'd9,    1'b0),
            checked_row(lcas_pkg::CMD_ADVANCE, 12'd0,    1'b0, 1'b0, 1'b1),
            model_row(lcas_pkg::CMD_READ,      12'd4095, 1'b0),
            model_row(lcas_pkg::CMD_READ,      12'd4,    1'b0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_REGS)
            begin
                await_idle();
                write_regs(directed_rows[k].side_word, directed_rows[k].birth,
                           directed_rows[k].survive);
            end
            else
            begin
                send_command(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].val,
                             directed_rows[k].fixed, directed_rows[k].want);
            end
        end

        random_phase(20, 1'b0);

        // Back-to-back commands against a held-off receiver fill the block.
        src_idle_pct = 0;
        random_phase(20, 1'b1);
        src_idle_pct = IDLE_PCT;

        random_phase(20, 1'b0);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(20, 1'b0);
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;

        repeat (2) random_phase(20, 1'b0);

        cmd_bus.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            flag_error($sformatf("%0d result beats never arrived", pending_results.size()));
        end

        if (fail_count == 0)
        begin
            $display("life_cellular_automaton_step verification clean");
        end
        else
        begin
            $display("life_cellular_automaton_step verification failed");
        end
        $finish;
    end

endmodule

### life_cellular_automaton_step.f
sv/lcas_pkg.sv
sv/lcas_ifs.sv
sv/lcas_grid_ram.sv
sv/life_cellular_automaton_step.sv
sv/lcas_checker.sv
dv/tb_life_cellular_automaton_step.sv
